// ===== hw/rtl/kwlex_pkg.sv =====
// Shared token kinds and character codes for the keyword token lexer.
`default_nettype none

package kwlex_pkg;

  typedef enum logic [3:0] {
    KIND_PUNCT   = 4'd0,
    KIND_INT     = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_DO      = 4'd3,
    KIND_ELSE    = 4'd4,
    KIND_IF      = 4'd5,
    KIND_WHILE   = 4'd6,
    KIND_END     = 4'd7,
    KIND_BAD_ID  = 4'd8,
    KIND_UNKNOWN = 4'd9
  } kind_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_H      = 8'h68;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_W      = 8'h77;
  localparam logic [7:0] CH_Z      = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Word buffer holds five letters; a length of six marks a longer word.
  localparam logic [2:0] WORD_MAX  = 3'd5;
  localparam logic [2:0] WORD_LONG = 3'd6;

endpackage

`default_nettype wire

// ===== hw/rtl/kwlex_ifs.sv =====
// Valid/ready channel interfaces for source bytes and emitted tokens.
`default_nettype none

interface kwlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface kwlex_out_if import kwlex_pkg::*; #(
  parameter int VALUE_BITS = 31,
  parameter int LINE_BITS  = 20
);
  logic                  valid;
  logic                  ready;
  kind_t                 token_kind;
  logic [7:0]            char_code;
  logic [VALUE_BITS-1:0] int_value;
  logic                  overflowed;
  logic [LINE_BITS-1:0]  line_number;
  logic                  last_of_run;

  modport source (output valid, output token_kind, output char_code, output int_value,
                  output overflowed, output line_number, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input char_code, input int_value,
                  input overflowed, input line_number, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/keyword_token_lexer.sv =====
// Keyword token lexer: one source byte per cycle in while the token queue has room, tokens out through it.
`default_nettype none

//  Channel | Dir | Payload                                           | Transfer when
//  --------+-----+---------------------------------------------------+----------------------
//  src     | in  | byte_in, end_of_input                             | src.valid & src.ready
//  tok     | out | token_kind, char_code, int_value, overflowed,     | tok.valid & tok.ready
//          |     | line_number, last_of_run                          |
//
// Flow: one item per cycle is accepted while the queue has room. An accepted item is held in the
// input register, is decoded there against the scanner state, and its zero, one or two tokens
// are written into a four-entry token queue. The queue drains one token per cycle while
// tok.ready is high, so the two tokens of one item leave it one after the other.
// Reset (rst, synchronous) returns the scanner to idle at line 1.
// Stalls: input is taken while the input register is empty or the queue holds at most two
// tokens, so src.ready never depends combinationally on tok.ready.

module keyword_token_lexer import kwlex_pkg::*; #(
  parameter int VALUE_BITS = 31,
  parameter int LINE_BITS  = 20
) (
  input  wire         clk,
  input  wire         rst,
  kwlex_in_if.sink    src,
  kwlex_out_if.source tok
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NUM  = 3'd1,
    MODE_WORD = 3'd2,
    MODE_CMT  = 3'd3,
    MODE_ERR  = 3'd4
  } mode_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            char_code;
    logic [VALUE_BITS-1:0] int_value;
    logic                  overflowed;
    logic [LINE_BITS-1:0]  line_number;
    logic                  last_of_run;
  } token_t;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);
  localparam int WIDE_BITS  = VALUE_BITS + 4;

  function automatic token_t mk_tok(kind_t k, logic [7:0] ch, logic [VALUE_BITS-1:0] v,
                                    logic ov, logic [LINE_BITS-1:0] ln);
    token_t t;
    t.kind        = k;
    t.char_code   = ch;
    t.int_value   = v;
    t.overflowed  = ov;
    t.line_number = ln;
    t.last_of_run = 1'b1;
    return t;
  endfunction

  // Input register: the accepted item waits here until it is decoded.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eoi;

  // Scanner state.
  mode_t                 mode, mode_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic                  over, over_next;
  logic [7:0]            wc [WORD_MAX];
  logic [2:0]            wlen, wlen_next;
  logic [LINE_BITS-1:0]  lc, lc_next;

  // Token queue.
  token_t                fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   head, tail;
  logic [CNT_BITS-1:0]   count;

  logic                  fire;
  logic                  pop;
  logic [1:0]            n_push;

  // Decode signals.
  logic                  is_digit, is_lower;
  logic [LINE_BITS-1:0]  lc_inc, fl_line;
  logic [WIDE_BITS-1:0]  acc_ext, acc10;
  logic                  acc_ovf;
  logic                  fl_valid, fl_err;
  token_t                fl_tok;
  logic                  a_valid, b_valid;
  token_t                tok_a, tok_b, slot0;
  logic                  wc_we;
  logic [2:0]            wc_idx;

  // The decode stage fires whenever the queue has room for the worst case of two tokens.
  assign fire      = in_valid && (count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign src.ready = !in_valid || fire;
  assign pop       = tok.valid && tok.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (src.ready) begin
      in_valid <= src.valid;
    end
    if (src.valid && src.ready) begin
      in_byte <= src.byte_in;
      in_eoi  <= src.end_of_input;
    end
  end

  assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign is_lower = (in_byte >= CH_A) && (in_byte <= CH_Z);
  assign lc_inc   = (lc == '1) ? lc : LINE_BITS'(lc + 1'b1);

  // Digit step: acc * 10 + d, formed by shifts, with headroom to spot saturation.
  assign acc_ext = {4'b0, acc};
  assign acc10   = WIDE_BITS'((acc_ext << 3) + (acc_ext << 1))
                 + WIDE_BITS'(in_byte[3:0]);
  assign acc_ovf = acc10 > {4'b0, {VALUE_BITS{1'b1}}};

  // A comment cut off by end of input counts as if it had closed with a newline.
  assign fl_line = (in_eoi && mode == MODE_CMT) ? lc_inc : lc;

  // Token that a terminator flushes out of a pending number or word.
  always_comb begin
    fl_valid = 1'b0;
    fl_err   = 1'b0;
    fl_tok   = mk_tok(KIND_INT, 8'd0, acc, over, fl_line);
    if (mode == MODE_NUM) begin
      fl_valid = 1'b1;
    end else if (mode == MODE_WORD) begin
      fl_valid = 1'b1;
      if (wlen == 3'd2 && wc[0] == CH_D && wc[1] == CH_O) begin
        fl_tok = mk_tok(KIND_DO, 8'd0, '0, 1'b0, fl_line);
      end else if (wlen == 3'd4 && wc[0] == CH_E && wc[1] == CH_L && wc[2] == CH_S
                   && wc[3] == CH_E) begin
        fl_tok = mk_tok(KIND_ELSE, 8'd0, '0, 1'b0, fl_line);
      end else if (wlen == 3'd2 && wc[0] == CH_I && wc[1] == CH_F) begin
        fl_tok = mk_tok(KIND_IF, 8'd0, '0, 1'b0, fl_line);
      end else if (wlen == 3'd5 && wc[0] == CH_W && wc[1] == CH_H && wc[2] == CH_I
                   && wc[3] == CH_L && wc[4] == CH_E) begin
        fl_tok = mk_tok(KIND_WHILE, 8'd0, '0, 1'b0, fl_line);
      end else if (wlen == 3'd1) begin
        fl_tok = mk_tok(KIND_IDENT, wc[0], '0, 1'b0, fl_line);
      end else begin
        fl_tok = mk_tok(KIND_BAD_ID, wc[0], '0, 1'b0, fl_line);
        fl_err = 1'b1;
      end
    end
  end

  // Main decode: next scanner state plus up to two tokens, flush token first.
  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    over_next = over;
    wlen_next = wlen;
    lc_next   = lc;
    wc_we     = 1'b0;
    wc_idx    = 3'd0;
    a_valid   = 1'b0;
    tok_a     = fl_tok;
    b_valid   = 1'b0;
    tok_b     = mk_tok(KIND_END, 8'd0, '0, 1'b0, fl_line);
    if (in_eoi) begin
      a_valid   = fl_valid;
      b_valid   = 1'b1;
      mode_next = MODE_IDLE;
      acc_next  = '0;
      over_next = 1'b0;
      wlen_next = 3'd0;
      lc_next   = LINE_BITS'(1);
    end else if (mode == MODE_ERR) begin
      // Sticky error: everything up to end of input is dropped.
    end else if (mode == MODE_CMT) begin
      if (in_byte == CH_LF) begin
        lc_next   = lc_inc;
        mode_next = MODE_IDLE;
      end
    end else if (mode == MODE_NUM && is_digit) begin
      if (acc_ovf) begin
        acc_next  = '1;
        over_next = 1'b1;
      end else begin
        acc_next  = acc10[VALUE_BITS-1:0];
      end
    end else if (mode == MODE_WORD && (is_lower || in_byte == CH_US)) begin
      if (wlen < WORD_MAX) begin
        wc_we     = 1'b1;
        wc_idx    = wlen;
        wlen_next = wlen + 3'd1;
      end else begin
        wlen_next = WORD_LONG;
      end
    end else begin
      // Terminator: flush whatever is pending, then treat the byte from idle.
      a_valid = fl_valid;
      if (fl_err) begin
        mode_next = MODE_ERR;
      end else begin
        mode_next = MODE_IDLE;
        case (in_byte) inside
          CH_SPACE, CH_TAB, CH_CR: begin
          end
          CH_HASH: begin
            mode_next = MODE_CMT;
          end
          CH_LF: begin
            lc_next = lc_inc;
          end
          CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS,
          CH_LT, CH_GT, CH_SEMI, CH_EQ: begin
            b_valid = 1'b1;
            tok_b   = mk_tok(KIND_PUNCT, in_byte, '0, 1'b0, lc);
          end
          [CH_0:CH_9]: begin
            mode_next = MODE_NUM;
            acc_next  = VALUE_BITS'(in_byte[3:0]);
            over_next = 1'b0;
          end
          [CH_A:CH_Z]: begin
            mode_next = MODE_WORD;
            wc_we     = 1'b1;
            wc_idx    = 3'd0;
            wlen_next = 3'd1;
          end
          default: begin
            // Unknown characters, a leading underscore among them.
            b_valid   = 1'b1;
            tok_b     = mk_tok(KIND_UNKNOWN, in_byte, '0, 1'b0, lc);
            mode_next = MODE_ERR;
          end
        endcase
      end
    end
    // Only the later of two tokens closes the run.
    tok_a.last_of_run = !b_valid;
  end

  assign n_push = fire ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
  assign slot0  = a_valid ? tok_a : tok_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      acc   <= '0;
      over  <= 1'b0;
      wlen  <= 3'd0;
      lc    <= LINE_BITS'(1);
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (fire) begin
        mode <= mode_next;
        acc  <= acc_next;
        over <= over_next;
        wlen <= wlen_next;
        lc   <= lc_next;
      end
      if (pop) begin
        head <= PTR_BITS'(head + 1'b1);
      end
      tail  <= PTR_BITS'(tail + n_push);
      count <= CNT_BITS'(count + CNT_BITS'(n_push) - CNT_BITS'(pop));
    end
    if (fire && wc_we) begin
      wc[wc_idx] <= in_byte;
    end
    if (n_push != 2'd0) begin
      fifo[tail] <= slot0;
    end
    if (n_push == 2'd2) begin
      fifo[PTR_BITS'(tail + 1'b1)] <= tok_b;
    end
  end

  assign tok.valid       = (count != '0);
  assign tok.token_kind  = fifo[head].kind;
  assign tok.char_code   = fifo[head].char_code;
  assign tok.int_value   = fifo[head].int_value;
  assign tok.overflowed  = fifo[head].overflowed;
  assign tok.line_number = fifo[head].line_number;
  assign tok.last_of_run = fifo[head].last_of_run;

`ifndef SYNTHESIS
  // The queue never holds more tokens than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(FIFO_DEPTH))
    else $error("token queue overfilled");

  // End of input always leaves the scanner idle at line one.
  a_eoi_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && in_eoi) |=> (mode == MODE_IDLE && lc == LINE_BITS'(1)))
    else $error("end of input did not restart the scanner");

  // The error mode is left only through end of input.
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ERR && !(fire && in_eoi)) |=> (mode == MODE_ERR))
    else $error("error mode cleared before end of input");

  // The last token of an end-of-input run is always the end token.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (fire && in_eoi) |-> (b_valid && tok_b.kind == KIND_END && !tok_a.last_of_run))
    else $error("end token not closing its run");
`endif

endmodule

`default_nettype wire
